>>> src/lt8900enc_pkg.sv
// Package for the LT8900 frame encoder: word types, queue entry type,
// register indexes and constants. No dependencies.
package lt8900enc_pkg;

  localparam int unsigned MAX_FRAME_DFLT = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;

  localparam logic [7:0]  PRE_ODD    = 8'h55;
  localparam logic [7:0]  PRE_EVEN   = 8'hAA;
  localparam logic [3:0]  AW_MAX     = 4'd5;
  localparam logic [15:0] CRC16_TAPS = 16'h8408;

  localparam logic [3:0]  RST_PREAMBLE = 4'd3;
  localparam logic        RST_LONG     = 1'b1;
  localparam logic [15:0] RST_SYNC_LO  = 16'h0000;
  localparam logic [15:0] RST_SYNC_HI  = 16'h0000;
  localparam logic [4:0]  RST_TRAILER  = 5'd4;
  localparam logic        RST_CRC_EN   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREAMBLE = 3'd0,
    CFG_LONG     = 3'd1,
    CFG_SYNC_LO  = 3'd2,
    CFG_SYNC_HI  = 3'd3,
    CFG_TRAILER  = 3'd4,
    CFG_CRC_EN   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] air_byte;
    logic       frame_end;
    logic       overflow;
  } out_word_t;

  // classified word as handed from the front to the back
  typedef struct packed {
    logic [7:0]  payload;
    logic        last;
    logic        first;
    logic        crc_en;
    logic [3:0]  hdr_lo;    // first header byte index to send
    logic [3:0]  hdr_hi;    // one past the last header byte index
    logic [3:0]  pre_end;   // preamble length
    logic [3:0]  sync_end;  // preamble plus syncword length
    logic [2:0]  rem;       // partial trailer bits
    logic [7:0]  pre_byte;
    logic [31:0] sync;
  } q_entry_t;

endpackage

>>> src/lt8900enc_front.sv
// Front end: configuration registers, input acceptance and classification
// of each payload word into a queue entry. Depends on lt8900enc_pkg.
module lt8900enc_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lt8900enc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lt8900enc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  lt8900enc_pkg::in_word_t            in_word_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output lt8900enc_pkg::q_entry_t            q_entry_o
);
  import lt8900enc_pkg::*;

  logic [3:0]  pre_q;
  logic        long_q;
  logic [15:0] sync_lo_q;
  logic [15:0] sync_hi_q;
  logic [4:0]  trl_q;
  logic        crc_en_q;
  logic        first_q, first_d;

  logic [3:0] p, s, aw;
  logic [4:0] t_cl, t_ev, aw_raw, hi_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q     <= RST_PREAMBLE;
      long_q    <= RST_LONG;
      sync_lo_q <= RST_SYNC_LO;
      sync_hi_q <= RST_SYNC_HI;
      trl_q     <= RST_TRAILER;
      crc_en_q  <= RST_CRC_EN;
      first_q   <= 1'b1;
    end else begin
      first_q <= first_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PREAMBLE: pre_q     <= cfg_wdata_i[3:0];
          CFG_LONG:     long_q    <= cfg_wdata_i[0];
          CFG_SYNC_LO:  sync_lo_q <= cfg_wdata_i;
          CFG_SYNC_HI:  sync_hi_q <= cfg_wdata_i;
          CFG_TRAILER:  trl_q     <= cfg_wdata_i[4:0];
          CFG_CRC_EN:   crc_en_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    first_d = first_q;
    if (q_push_o) begin
      first_d = in_word_i.last_byte;
    end
  end

  // clamp settings and work out which header bytes the address does not cover
  always_comb begin
    if (pre_q == 4'd0) begin
      p = 4'd1;
    end else if (pre_q > 4'd8) begin
      p = 4'd8;
    end else begin
      p = pre_q;
    end
    s = long_q ? 4'd4 : 4'd2;
    if (trl_q < 5'd4) begin
      t_cl = 5'd4;
    end else if (trl_q > 5'd18) begin
      t_cl = 5'd18;
    end else begin
      t_cl = trl_q;
    end
    t_ev   = {t_cl[4:1], 1'b0};
    aw_raw = {1'b0, p} - 5'd1 + {1'b0, s};
    aw     = (aw_raw > {1'b0, AW_MAX}) ? AW_MAX : aw_raw[3:0];
    hi_sum = {1'b0, p} + {1'b0, s} + {3'b000, t_ev[4:3]};
  end

  always_comb begin
    q_entry_o.payload  = in_word_i.payload_byte;
    q_entry_o.last     = in_word_i.last_byte;
    q_entry_o.first    = first_q;
    q_entry_o.crc_en   = crc_en_q;
    q_entry_o.hdr_lo   = aw + 4'd1;
    q_entry_o.hdr_hi   = hi_sum[3:0];
    q_entry_o.pre_end  = p;
    q_entry_o.sync_end = p + s;
    q_entry_o.rem      = t_ev[2:0];
    q_entry_o.pre_byte = sync_lo_q[0] ? PRE_ODD : PRE_EVEN;
    q_entry_o.sync     = {sync_hi_q, sync_lo_q};
  end

endmodule

>>> src/lt8900enc_queue.sv
// Short FIFO of classified entries between front and back.
// Depends on lt8900enc_pkg.
module lt8900enc_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  lt8900enc_pkg::q_entry_t  wdata_i,
  output logic                     full_o,
  input  logic                     pop_i,
  output logic                     valid_o,
  output lt8900enc_pkg::q_entry_t  rdata_o
);
  import lt8900enc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  q_entry_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

>>> src/lt8900enc_back.sv
// Back end: frame sequencer (header, payload packing, CRC, flush), frame
// length limit and the output register. Depends on lt8900enc_pkg.
module lt8900enc_back #(
  parameter int unsigned MAX_FRAME = lt8900enc_pkg::MAX_FRAME_DFLT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     head_valid_i,
  input  lt8900enc_pkg::q_entry_t  head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output lt8900enc_pkg::out_word_t out_word_o
);
  import lt8900enc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);

  typedef enum logic [2:0] {
    PH_PAY,
    PH_HDR,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_DRAIN
  } phase_e;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b_in);
    logic [15:0] c;
    logic [7:0]  b;
    c = c_in;
    b = b_in;
    for (int i = 0; i < 8; i++) begin
      if (b[0] ^ c[0]) begin
        c = (c >> 1) ^ CRC16_TAPS;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    return c;
  endfunction

  function automatic logic [7:0] hdr_byte(input q_entry_t e, input logic [3:0] q);
    logic [3:0] k;
    logic [7:0] b;
    k = q - e.pre_end;
    if (q < e.pre_end) begin
      b = e.pre_byte;
    end else if (q < e.sync_end) begin
      b = 8'(e.sync >> {k[1:0], 3'b000});
    end else begin
      b = e.payload[0] ? PRE_ODD : PRE_EVEN;
    end
    return b;
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic        hdr_done_q, hdr_done_d;
  logic [15:0] buf_q, buf_d;
  logic [3:0]  fill_q, fill_d;
  logic [15:0] crc_q, crc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_q, out_d;

  logic        go, can_out, hdr_step, push_en, load;
  logic        cand_vld, cand_final;
  logic [7:0]  cand_byte, push_val, trl_pat;
  logic [3:0]  idx_eff;
  logic [15:0] psum;
  logic [4:0]  pfill;

  assign can_out = !out_valid_q || out_ready_i;
  assign go      = head_valid_i && can_out;
  assign trl_pat = head_i.payload[0] ? PRE_ODD : PRE_EVEN;

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    hdr_done_d = hdr_done_q;
    buf_d      = buf_q;
    fill_d     = fill_q;
    crc_d      = crc_q;
    cnt_d      = cnt_q;
    pop_o      = 1'b0;
    hdr_step   = 1'b0;
    push_en    = 1'b0;
    push_val   = 8'h00;
    idx_eff    = idx_q;
    cand_vld   = 1'b0;
    cand_final = 1'b0;
    cand_byte  = 8'h00;
    load       = 1'b0;
    out_d      = out_q;
    psum       = 16'h0000;
    pfill      = 5'd0;

    if (go) begin
      unique case (phase_q)
        PH_PAY: begin
          if (head_i.first && !hdr_done_q) begin
            hdr_step = 1'b1;
            idx_eff  = head_i.hdr_lo;
          end else begin
            push_en  = 1'b1;
            push_val = head_i.payload;
            crc_d    = crc_byte(crc_q, head_i.payload);
            if (head_i.last) begin
              phase_d = head_i.crc_en ? PH_CRC_LO : PH_DRAIN;
            end else begin
              pop_o      = 1'b1;
              hdr_done_d = 1'b0;
            end
          end
        end
        PH_HDR: hdr_step = 1'b1;
        PH_CRC_LO: begin
          push_en  = 1'b1;
          push_val = crc_q[7:0];
          phase_d  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          push_en  = 1'b1;
          push_val = crc_q[15:8];
          phase_d  = PH_DRAIN;
        end
        PH_DRAIN: begin
          // flush is always exactly one byte: fill is never zero here
          cand_vld   = 1'b1;
          cand_final = 1'b1;
          cand_byte  = buf_q[7:0];
          buf_d      = 16'h0000;
          fill_d     = 4'd0;
          crc_d      = 16'h0000;
          pop_o      = 1'b1;
          hdr_done_d = 1'b0;
          phase_d    = PH_PAY;
        end
        default: phase_d = PH_PAY;
      endcase
    end

    if (hdr_step) begin
      if (idx_eff < head_i.hdr_hi) begin
        cand_vld  = 1'b1;
        cand_byte = hdr_byte(head_i, idx_eff);
        idx_d     = idx_eff + 4'd1;
        phase_d   = PH_HDR;
      end else begin
        // seed the bit buffer with the partial trailer bits
        buf_d      = {8'h00, trl_pat >> (4'd8 - {1'b0, head_i.rem})};
        fill_d     = {1'b0, head_i.rem};
        hdr_done_d = 1'b1;
        phase_d    = PH_PAY;
      end
    end

    if (push_en) begin
      psum  = buf_q | (16'(push_val) << fill_q);
      pfill = {1'b0, fill_q} + 5'd8;
      if (pfill > 5'd8) begin
        cand_vld  = 1'b1;
        cand_byte = psum[7:0];
        buf_d     = psum >> 8;
        fill_d    = 4'(pfill - 5'd8);
      end else begin
        buf_d  = psum;
        fill_d = 4'd8;
      end
    end

    if (cand_vld) begin
      if (cand_final) begin
        load = 1'b1;
        cnt_d = '0;
        if (cnt_q < CNT_MAX) begin
          out_d = '{air_byte: rev8(cand_byte), frame_end: 1'b1, overflow: 1'b0};
        end else begin
          out_d = '{air_byte: 8'h00, frame_end: 1'b1, overflow: 1'b1};
        end
      end else if (cnt_q < CNT_MAX) begin
        load  = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        out_d = '{air_byte: rev8(cand_byte), frame_end: 1'b0, overflow: 1'b0};
      end
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PAY;
      idx_q       <= 4'd0;
      hdr_done_q  <= 1'b0;
      buf_q       <= 16'h0000;
      fill_q      <= 4'd0;
      crc_q       <= 16'h0000;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      hdr_done_q  <= hdr_done_d;
      buf_q       <= buf_d;
      fill_q      <= fill_d;
      crc_q       <= crc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> src/lt8900_frame_over_nrf24_encoder.sv
// LT8900 frame encoder, top level: front, queue and back.
// Depends on lt8900enc_pkg, lt8900enc_front, lt8900enc_queue, lt8900enc_back.
//
// Input channel (in_valid_i/in_ready_o/in_word_i) takes one payload word per
// cycle while in_ready_o is high, last_byte set on the packet's final word.
// Output channel (out_valid_o/out_ready_i/out_word_o) gives the bit-reversed
// air bytes. The user must write the registers (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) only while idle; the block itself does not enforce this.
// The back's sequencer produces at most one byte per cycle. In the body of a
// packet it takes one word per cycle while the output is not stalled; the
// first word also makes it send the header bytes and seed the bit buffer with
// trailer bits, and the last word the two CRC bytes (if enabled) and a flush.
// When the receiver stalls, the output register holds its word, the back
// stops, and the two-entry queue fills before in_ready_o drops.
// Reset clears the queue, the sequencer and the frame state and loads the
// register defaults; the block is ready in the first cycle after reset.
module lt8900_frame_over_nrf24_encoder #(
  parameter int unsigned MAX_FRAME = lt8900enc_pkg::MAX_FRAME_DFLT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lt8900enc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lt8900enc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  lt8900enc_pkg::in_word_t              in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output lt8900enc_pkg::out_word_t             out_word_o
);
  import lt8900enc_pkg::*;

  logic     q_push, q_full, q_pop, q_valid;
  q_entry_t q_wdata, q_head;

  lt8900enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_wdata)
  );

  lt8900enc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_head)
  );

  lt8900enc_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.overflow |-> out_word_o.frame_end && out_word_o.air_byte == 8'h00)
    else $error("overflow marker malformed");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> q_valid)
    else $error("accepted word not queued");

endmodule
